[hw/rtl/tdc_pkg.sv]
`timescale 1ns / 1ps

package tdc_pkg;

    // Widths of the channel payloads and the config register
    localparam int CHAR_W = 7;
    localparam int TPS_W  = 7;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Reset value of ticks_per_second
    localparam logic [TPS_W-1:0] TPS_RESET = 7'd125;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BLANK = 7'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_E     = 7'h45;
    localparam logic [CHAR_W-1:0] CH_R     = 7'h52;
    localparam logic [CHAR_W-1:0] CH_O     = 7'h4F;
    localparam logic [CHAR_W-1:0] CH_BANG  = 7'h21;

    // Character positions within one run
    localparam logic [3:0] POS_LAST_TIME = 4'd7;
    localparam logic [3:0] POS_LAST_ERR  = 4'd13;

    // One time snapshot handed from front to back, kept as decimal digits
    typedef struct packed {
        logic [1:0] h_tens;
        logic [3:0] h_ones;
        logic [2:0] m_tens;
        logic [3:0] m_ones;
        logic [2:0] s_tens;
        logic [3:0] s_ones;
        logic       err;
    } t_snap;

    // Queue head as seen by the back part
    typedef struct packed {
        logic  valid;
        t_snap snap;
    } t_head;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        digit_char = CH_ZERO + {3'b000, d};
    endfunction

endpackage

[hw/rtl/tdc_if.sv]
`timescale 1ns / 1ps

// Tick channel: one word per timer compare tick
interface tdc_tick_if;
    logic valid;
    logic ready;
    logic overflow_flag;

    modport source (output valid, output overflow_flag, input ready);
    modport sink   (input valid, input overflow_flag, output ready);
endinterface

// Character channel: one word per display character
interface tdc_char_if;
    import tdc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[hw/rtl/tdc_front.sv]
`timescale 1ns / 1ps

module tdc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tdc_tick_if.sink                    i_tick,
    input  logic                        i_cfg_we,
    input  logic [tdc_pkg::TPS_W-1:0]   i_cfg_wdata,
    input  logic                        i_q_full,
    output logic                        o_push,
    output tdc_pkg::t_snap              o_snap
);
    import tdc_pkg::*;

    logic [TPS_W-1:0] r_tps;
    logic [TPS_W-1:0] r_tick_cnt;
    logic [TPS_W-1:0] n_tick_cnt;
    logic             r_halted;
    t_snap            r_time;
    t_snap            n_time;
    logic             w_take;
    logic             w_second;

    // Accept freely once halted; otherwise hold off while the queue is full
    assign i_tick.ready = r_halted | ~i_q_full;
    assign w_take       = i_tick.valid & i_tick.ready & ~r_halted;
    assign n_tick_cnt   = r_tick_cnt + 1'b1;
    assign w_second     = w_take & (n_tick_cnt == r_tps);

    // Advance the clock digits by one second and take the error flag from the tick
    always_comb begin
        n_time     = r_time;
        n_time.err = i_tick.overflow_flag;
        if (r_time.s_ones != 4'd9) begin
            n_time.s_ones = r_time.s_ones + 4'd1;
        end else begin
            n_time.s_ones = 4'd0;
            if (r_time.s_tens != 3'd5) begin
                n_time.s_tens = r_time.s_tens + 3'd1;
            end else begin
                n_time.s_tens = 3'd0;
                if (r_time.m_ones != 4'd9) begin
                    n_time.m_ones = r_time.m_ones + 4'd1;
                end else begin
                    n_time.m_ones = 4'd0;
                    if (r_time.m_tens != 3'd5) begin
                        n_time.m_tens = r_time.m_tens + 3'd1;
                    end else begin
                        n_time.m_tens = 3'd0;
                        priority if (r_time.h_tens == 2'd2 && r_time.h_ones == 4'd3) begin
                            n_time.h_tens = 2'd0;
                            n_time.h_ones = 4'd0;
                        end else if (r_time.h_ones == 4'd9) begin
                            n_time.h_tens = r_time.h_tens + 2'd1;
                            n_time.h_ones = 4'd0;
                        end else begin
                            n_time.h_ones = r_time.h_ones + 4'd1;
                        end
                    end
                end
            end
        end
    end

    assign o_push = w_second;
    assign o_snap = n_time;

    // Hold config, prescaler, time and halt flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps         <= TPS_RESET;
            r_tick_cnt    <= '0;
            r_halted      <= 1'b0;
            r_time.h_tens <= 2'd2;
            r_time.h_ones <= 4'd3;
            r_time.m_tens <= 3'd5;
            r_time.m_ones <= 4'd9;
            r_time.s_tens <= 3'd5;
            r_time.s_ones <= 4'd0;
            r_time.err    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            if (w_take) begin
                r_tick_cnt <= w_second ? '0 : n_tick_cnt;
            end
            if (w_second) begin
                r_time <= n_time;
                if (i_tick.overflow_flag) begin
                    r_halted <= 1'b1;
                end
            end
        end
    end

endmodule

[hw/rtl/tdc_queue.sv]
`timescale 1ns / 1ps

module tdc_queue #(
    parameter int DEPTH = tdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tdc_pkg::t_snap i_snap,
    output logic           o_full,
    output tdc_pkg::t_head o_head,
    input  logic           i_pop
);
    import tdc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_snap           r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.snap  = r_mem[r_rd_ptr];
    assign w_push      = i_push & ~o_full;
    assign w_pop       = i_pop & o_head.valid;

    // Store snapshots
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_snap;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/tdc_back.sv]
`timescale 1ns / 1ps

module tdc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tdc_pkg::t_head i_head,
    output logic           o_pop,
    tdc_char_if.source     o_char
);
    import tdc_pkg::*;

    logic [3:0]        r_pos;
    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic [CHAR_W-1:0] w_char;
    logic              w_last;
    logic              w_load;

    // Pick the character at the current position of the run
    always_comb begin
        unique case (r_pos)
            4'd0:    w_char = (i_head.snap.h_tens == 2'd0) ? CH_BLANK
                              : digit_char({2'b00, i_head.snap.h_tens});
            4'd1:    w_char = digit_char(i_head.snap.h_ones);
            4'd2:    w_char = CH_COLON;
            4'd3:    w_char = digit_char({1'b0, i_head.snap.m_tens});
            4'd4:    w_char = digit_char(i_head.snap.m_ones);
            4'd5:    w_char = CH_COLON;
            4'd6:    w_char = digit_char({1'b0, i_head.snap.s_tens});
            4'd7:    w_char = digit_char(i_head.snap.s_ones);
            4'd8:    w_char = CH_E;
            4'd9:    w_char = CH_R;
            4'd10:   w_char = CH_R;
            4'd11:   w_char = CH_O;
            4'd12:   w_char = CH_R;
            4'd13:   w_char = CH_BANG;
            default: w_char = CH_BLANK;
        endcase
    end

    assign w_last = ((r_pos == POS_LAST_TIME) && !i_head.snap.err) || (r_pos == POS_LAST_ERR);
    assign w_load = i_head.valid & (~r_valid | o_char.ready);
    assign o_pop  = w_load & w_last;

    assign o_char.valid     = r_valid;
    assign o_char.char_code = r_char;
    assign o_char.last_char = r_last;

    // Load the output register and step through the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_pos   <= w_last ? 4'd0 : r_pos + 4'd1;
            end else if (o_char.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= w_char;
            r_last <= w_last;
        end
    end

endmodule

[hw/rtl/time_of_day_clock_display.sv]
`timescale 1ns / 1ps

// 24-hour time-of-day clock with a character stream for a text display.
// i_tick carries one word per timer compare tick (overflow_flag). After
// ticks_per_second ticks one second passes; the clock advances and emits
// "hh:mm:ss" (hour tens blank below ten) on o_char, one character per word.
// If overflow_flag is set on that tick, "ERROR!" follows and the block
// halts: later ticks are taken and dropped. last_char marks the final word
// of each run. i_cfg_we / i_cfg_wdata write ticks_per_second.
// Ticks are taken one per cycle while the queue is not full. A completed
// second is written into the queue, then its characters pass through the
// single output register to o_char, one per cycle while o_char is not
// stalled; a run is 8 or 14 characters.
// Up to QUEUE_DEPTH seconds wait in the queue; whenever it is full (o_char
// stalled, or seconds arriving faster than runs drain) i_tick.ready drops
// until the back part frees an entry. Once halted, i_tick.ready stays high.
// Reset (synchronous, active low) gives 23:59:50, prescaler zero,
// ticks_per_second 125, queue empty and o_char idle.
module time_of_day_clock_display #(
    parameter int QUEUE_DEPTH = tdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tdc_tick_if.sink                  i_tick,
    tdc_char_if.source                o_char,
    input  logic                      i_cfg_we,
    input  logic [tdc_pkg::TPS_W-1:0] i_cfg_wdata
);
    import tdc_pkg::*;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    t_snap w_snap;
    t_head w_head;

    tdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (i_tick),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_snap      (w_snap)
    );

    tdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_snap  (w_snap),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    tdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_char  (o_char)
    );

endmodule

[hw/rtl/tdc_checker.sv]
`timescale 1ns / 1ps

module tdc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [tdc_pkg::CHAR_W-1:0] i_char_code,
    input logic                       i_last_char
);
    import tdc_pkg::*;

    // A stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_char_code) && $stable(i_last_char))
        else $error("output word changed while stalled");

    // Reset leaves the output idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

    // A run never ends on a separator
    a_colon_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_char_code == CH_COLON) |-> !i_last_char)
        else $error("run ended on a colon");

    // A run ends on a seconds digit or on the bang of the error text
    a_last_char_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last_char |->
            (i_char_code >= CH_ZERO && i_char_code <= CH_ZERO + 7'd9) ||
            (i_char_code == CH_BANG))
        else $error("unexpected final character");

endmodule

bind time_of_day_clock_display tdc_checker u_tdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_char.valid),
    .i_ready     (o_char.ready),
    .i_char_code (o_char.char_code),
    .i_last_char (o_char.last_char)
);
